/* design/sca_pkg.sv */
// shared types, constants and helpers for the smtp command address extractor
// no dependencies; used by sca_front, sca_queue, sca_back, the top level and the testbench
package sca_pkg;

    // character codes
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // command words, left aligned in eight characters
    localparam int unsigned WORD_CHARS = 8;
    localparam logic [63:0] W_MAILFROM = "MAILFROM";
    localparam logic [63:0] W_RCPTTO   = {"RCPTTO", 16'h0000};
    localparam logic [63:0] W_DATA     = {"DATA", 32'h0000_0000};
    localparam logic [63:0] W_RSET     = {"RSET", 32'h0000_0000};
    localparam logic [63:0] W_MAIL     = {"MAIL", 32'h0000_0000};
    localparam logic [63:0] W_RCPT     = {"RCPT", 32'h0000_0000};

    // width of the letter count seen by the word matcher (covers up to 31 letters)
    localparam int unsigned MATCH_CNT_W = 5;

    // result queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_WORD,
        PH_SKIP,
        PH_FIRST,
        PH_COPY,
        PH_IGNORE,
        PH_ENDED
    } t_phase;

    typedef enum logic [1:0] {
        DL_START,
        DL_DOT,
        DL_DOTCR,
        DL_MID
    } t_dline;

    typedef enum logic [2:0] {
        CODE_OTHER,
        CODE_MAILFROM,
        CODE_RCPTTO,
        CODE_DATA,
        CODE_RSET,
        CODE_INCOMPLETE,
        CODE_DATA_LINE,
        CODE_DATA_END
    } t_code;

    typedef enum logic {
        KIND_ADDRESS,
        KIND_SUMMARY
    } t_kind;

    // all results caused by one input byte: space, address char, summary
    typedef struct packed {
        logic       sp_valid;
        logic       ch_valid;
        logic [7:0] ch;
        t_code      addr_code;
        logic       sum_valid;
        t_code      sum_code;
    } t_bundle;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (b >= CH_LO_A && b <= CH_LO_Z) begin
            return b - CASE_OFS;
        end
        return b;
    endfunction

    // first eight letters are packed with letter 0 in the top byte
    function automatic logic word_is(input logic [63:0] letters,
                                     input logic [MATCH_CNT_W-1:0] cnt,
                                     input logic [63:0] word,
                                     input logic [3:0] len);
        logic ok;
        ok = (cnt == MATCH_CNT_W'(len));
        for (int i = 0; i < WORD_CHARS; i++) begin
            if (4'(i) < len && letters[63-8*i -: 8] != word[63-8*i -: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic t_code classify(input logic [63:0] letters,
                                       input logic [MATCH_CNT_W-1:0] cnt);
        if (word_is(letters, cnt, W_MAILFROM, 4'd8)) return CODE_MAILFROM;
        if (word_is(letters, cnt, W_RCPTTO, 4'd6)) return CODE_RCPTTO;
        if (word_is(letters, cnt, W_DATA, 4'd4)) return CODE_DATA;
        if (word_is(letters, cnt, W_RSET, 4'd4)) return CODE_RSET;
        return CODE_OTHER;
    endfunction

    function automatic logic is_join_word(input logic [63:0] letters,
                                          input logic [MATCH_CNT_W-1:0] cnt);
        return word_is(letters, cnt, W_MAIL, 4'd4) || word_is(letters, cnt, W_RCPT, 4'd4);
    endfunction

endpackage

/* design/sca_in_if.sv */
// input byte channel: valid/ready with one stream byte and its packet mark
// no dependencies
interface sca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_packet;

    modport source (output valid, output data_byte, output last_of_packet, input ready);
    modport sink (input valid, input data_byte, input last_of_packet, output ready);
endinterface

/* design/sca_out_if.sv */
// result channel: valid/ready with one address byte or packet summary
// no dependencies
interface sca_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] address_byte;
    logic       address_target;
    logic [2:0] command_code;
    logic       is_last;

    modport source (output valid, output item_kind, output address_byte,
                    output address_target, output command_code, output is_last,
                    input ready);
    modport sink (input valid, input item_kind, input address_byte,
                  input address_target, input command_code, input is_last,
                  output ready);
endinterface

/* design/sca_front.sv */
// front end: parses one byte per transfer and builds the bundle of results it causes
// depends on sca_pkg and sca_in_if
module sca_front #(
    parameter int unsigned ADDRESS_BYTES = 128,
    parameter int unsigned COMMAND_CHARS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sca_in_if.sink               i_in,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output sca_pkg::t_bundle     o_q_bundle
);

    localparam int unsigned CW  = $clog2(COMMAND_CHARS + 1);
    localparam int unsigned IW  = $clog2(COMMAND_CHARS);
    localparam int unsigned AW  = $clog2(ADDRESS_BYTES);
    localparam int unsigned LIM = ADDRESS_BYTES - 1;
    localparam int unsigned FW  = sca_pkg::MATCH_CNT_W;

    logic                  r_dmode, n_dmode;
    sca_pkg::t_phase       r_phase, n_phase;
    logic [7:0]            r_letters [COMMAND_CHARS];
    logic [7:0]            n_letters [COMMAND_CHARS];
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_acnt, n_acnt;
    logic [1:0]            r_srun, n_srun;
    logic                  r_lcr, n_lcr;
    sca_pkg::t_dline       r_dls, n_dls;

    logic                  accept;
    logic [7:0]            b;
    logic                  ws;
    logic [63:0]           pre8;
    logic [63:0]           post8;
    logic                  take_word;
    logic                  do_parm;
    logic                  fl;
    logic                  fl_strip;
    logic                  put_ch;
    logic                  line_end;
    sca_pkg::t_code        addr_code;
    sca_pkg::t_code        post_code;
    sca_pkg::t_bundle      bnd;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_full;
    assign b         = i_in.data_byte;
    assign ws        = sca_pkg::is_ws(b);

    // first letters of the stored word, for the matchers
    always_comb begin
        for (int i = 0; i < sca_pkg::WORD_CHARS; i++) begin
            pre8[63-8*i -: 8] = r_letters[i];
        end
    end

    // one parse step over the current byte
    always_comb begin
        n_dmode   = r_dmode;
        n_phase   = r_phase;
        n_letters = r_letters;
        n_count   = r_count;
        n_acnt    = r_acnt;
        n_srun    = r_srun;
        n_lcr     = r_lcr;
        n_dls     = r_dls;
        take_word = 1'b0;
        do_parm   = 1'b0;
        fl        = 1'b0;
        fl_strip  = 1'b0;
        put_ch    = 1'b0;
        line_end  = 1'b0;
        post8     = pre8;
        addr_code = sca_pkg::CODE_OTHER;
        post_code = sca_pkg::CODE_OTHER;
        bnd       = '0;
        bnd.ch    = b;

        if (r_dmode) begin
            // end-of-data line tracking
            case (r_dls)
                sca_pkg::DL_START: begin
                    n_dls = (b == sca_pkg::CH_DOT) ? sca_pkg::DL_DOT :
                            (b == sca_pkg::CH_LF) ? sca_pkg::DL_START : sca_pkg::DL_MID;
                end
                sca_pkg::DL_DOT: begin
                    if (b == sca_pkg::CH_LF) begin
                        line_end = 1'b1;
                    end else begin
                        n_dls = (b == sca_pkg::CH_CR) ? sca_pkg::DL_DOTCR : sca_pkg::DL_MID;
                    end
                end
                sca_pkg::DL_DOTCR: begin
                    if (b == sca_pkg::CH_LF) begin
                        line_end = 1'b1;
                    end else begin
                        n_dls = sca_pkg::DL_MID;
                    end
                end
                default: begin
                    n_dls = (b == sca_pkg::CH_LF) ? sca_pkg::DL_START : sca_pkg::DL_MID;
                end
            endcase
            if (line_end) begin
                n_dmode = 1'b0;
                n_dls   = sca_pkg::DL_START;
                n_phase = sca_pkg::PH_ENDED;
            end
        end else begin
            // command word and parameter phases
            if (n_phase == sca_pkg::PH_LEAD && !ws) begin
                n_phase = sca_pkg::PH_WORD;
            end
            if (n_phase == sca_pkg::PH_WORD) begin
                take_word = 1'b1;
            end else if (n_phase == sca_pkg::PH_SKIP) begin
                if (!ws) begin
                    if (sca_pkg::is_join_word(pre8, FW'(r_count))) begin
                        n_phase   = sca_pkg::PH_WORD;
                        take_word = 1'b1;
                    end else if (sca_pkg::classify(pre8, FW'(r_count)) inside
                                 {sca_pkg::CODE_MAILFROM, sca_pkg::CODE_RCPTTO}) begin
                        n_phase = sca_pkg::PH_FIRST;
                        do_parm = 1'b1;
                    end else begin
                        n_phase = sca_pkg::PH_IGNORE;
                    end
                end
            end else if (n_phase == sca_pkg::PH_FIRST || n_phase == sca_pkg::PH_COPY) begin
                do_parm = 1'b1;
            end

            if (take_word) begin
                if (b == sca_pkg::CH_COLON || ws) begin
                    n_phase = sca_pkg::PH_SKIP;
                end else if (r_count < CW'(COMMAND_CHARS)) begin
                    n_letters[r_count[IW-1:0]] = sca_pkg::upcase(b);
                    n_count = r_count + 1'b1;
                end
            end

            if (do_parm) begin
                if (n_phase == sca_pkg::PH_FIRST) begin
                    n_phase = sca_pkg::PH_COPY;
                end
                if (r_phase == sca_pkg::PH_COPY || b != sca_pkg::CH_LT) begin
                    if (b == sca_pkg::CH_LF) begin
                        fl       = 1'b1;
                        fl_strip = 1'b1;
                        n_phase  = sca_pkg::PH_IGNORE;
                    end else if (b == sca_pkg::CH_GT) begin
                        fl      = 1'b1;
                        n_phase = sca_pkg::PH_IGNORE;
                    end else if (ws) begin
                        if (n_srun != 2'd2) begin
                            n_srun = n_srun + 1'b1;
                        end
                        n_lcr = (b == sca_pkg::CH_CR);
                    end else begin
                        fl     = 1'b1;
                        put_ch = 1'b1;
                    end
                end
            end
        end

        for (int i = 0; i < sca_pkg::WORD_CHARS; i++) begin
            post8[63-8*i -: 8] = n_letters[i];
        end
        post_code = sca_pkg::classify(post8, FW'(n_count));
        addr_code = post_code;

        // pending whitespace run closes at packet end with a trailing cr stripped
        if (i_in.last_of_packet && n_phase == sca_pkg::PH_COPY && !fl) begin
            fl       = 1'b1;
            fl_strip = 1'b1;
        end

        // collapsed space, then the address char, each under the length limit
        if (fl) begin
            if (n_srun != 2'd0 && !(fl_strip && n_srun == 2'd1 && n_lcr)) begin
                if (n_acnt < AW'(LIM)) begin
                    n_acnt       = n_acnt + 1'b1;
                    bnd.sp_valid = 1'b1;
                end
            end
            n_srun = 2'd0;
            n_lcr  = 1'b0;
        end
        if (put_ch && n_acnt < AW'(LIM)) begin
            n_acnt       = n_acnt + 1'b1;
            bnd.ch_valid = 1'b1;
        end
        bnd.addr_code = addr_code;

        // packet summary
        if (i_in.last_of_packet) begin
            bnd.sum_valid = 1'b1;
            if (n_dmode) begin
                bnd.sum_code = sca_pkg::CODE_DATA_LINE;
            end else if (n_phase == sca_pkg::PH_ENDED) begin
                bnd.sum_code = sca_pkg::CODE_DATA_END;
            end else if ((n_phase == sca_pkg::PH_WORD || n_phase == sca_pkg::PH_SKIP) &&
                         sca_pkg::is_join_word(post8, FW'(n_count))) begin
                bnd.sum_code = sca_pkg::CODE_INCOMPLETE;
            end else begin
                bnd.sum_code = post_code;
                if (post_code == sca_pkg::CODE_DATA) begin
                    n_dmode = 1'b1;
                    n_dls   = sca_pkg::DL_START;
                end else if (post_code == sca_pkg::CODE_RSET) begin
                    n_dmode = 1'b0;
                end
            end
            n_phase = sca_pkg::PH_LEAD;
            n_count = '0;
            n_acnt  = '0;
            n_srun  = 2'd0;
            n_lcr   = 1'b0;
        end
    end

    assign o_q_push   = accept && (bnd.sp_valid || bnd.ch_valid || bnd.sum_valid);
    assign o_q_bundle = bnd;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmode <= 1'b0;
            r_phase <= sca_pkg::PH_LEAD;
            r_count <= '0;
            r_acnt  <= '0;
            r_srun  <= 2'd0;
            r_lcr   <= 1'b0;
            r_dls   <= sca_pkg::DL_START;
        end else if (accept) begin
            r_dmode <= n_dmode;
            r_phase <= n_phase;
            r_count <= n_count;
            r_acnt  <= n_acnt;
            r_srun  <= n_srun;
            r_lcr   <= n_lcr;
            r_dls   <= n_dls;
        end
    end

    // command letters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_letters <= n_letters;
        end
    end

`ifndef ASSERT_OFF
    a_dmode_idle_parser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dmode |-> r_phase == sca_pkg::PH_LEAD)
        else $error("data mode with command parse in progress");

    a_acnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acnt <= AW'(LIM))
        else $error("address count past limit");

    a_packet_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_of_packet |=> r_count == '0 && r_acnt == '0 &&
        r_phase == sca_pkg::PH_LEAD)
        else $error("packet end did not clear parser counts");
`endif

endmodule

/* design/sca_queue.sv */
// short queue of result bundles between the parser and the output stage
// depends on sca_pkg
module sca_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sca_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output sca_pkg::t_bundle  o_head
);

    sca_pkg::t_bundle                r_mem [sca_pkg::QUEUE_DEPTH];
    logic [sca_pkg::QUEUE_AW-1:0]    r_wr, r_rd;
    logic [sca_pkg::QUEUE_CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == sca_pkg::QUEUE_CW'(sca_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != sca_pkg::QUEUE_CW'(sca_pkg::QUEUE_DEPTH) |->
        r_wr - r_rd == r_cnt[sca_pkg::QUEUE_AW-1:0])
        else $error("queue count out of step with pointers");
`endif

endmodule

/* design/sca_back.sv */
// back end: splits each bundle into result items, one per transfer, behind an output register
// depends on sca_pkg and sca_out_if
module sca_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  sca_pkg::t_bundle  i_q_head,
    output logic              o_q_pop,
    sca_out_if.source         o_out
);

    logic                r_valid;
    logic                r_kind;
    logic [7:0]          r_byte;
    logic                r_target;
    sca_pkg::t_code      r_code;
    logic                r_last;
    logic [2:0]          r_done, n_done;

    logic                load;
    logic [2:0]          mask;
    logic [2:0]          rem;
    logic [2:0]          sel;

    assign load = !r_valid || o_out.ready;
    assign mask = {i_q_head.sum_valid, i_q_head.ch_valid, i_q_head.sp_valid};
    assign rem  = i_q_empty ? 3'b000 : (mask & ~r_done);
    assign sel  = rem & (~rem + 3'b001);

    // mark emitted items and retire the bundle after its last one
    always_comb begin
        n_done  = r_done;
        o_q_pop = 1'b0;
        if (load && rem != 3'b000) begin
            if (rem == sel) begin
                o_q_pop = 1'b1;
                n_done  = 3'b000;
            end else begin
                n_done = r_done | sel;
            end
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_valid <= (rem != 3'b000);
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && rem != 3'b000) begin
            if (sel[2]) begin
                r_kind   <= sca_pkg::KIND_SUMMARY;
                r_byte   <= 8'h00;
                r_target <= 1'b0;
                r_code   <= i_q_head.sum_code;
                r_last   <= 1'b1;
            end else begin
                r_kind   <= sca_pkg::KIND_ADDRESS;
                r_byte   <= sel[0] ? sca_pkg::CH_SP : i_q_head.ch;
                r_target <= (i_q_head.addr_code == sca_pkg::CODE_RCPTTO);
                r_code   <= i_q_head.addr_code;
                r_last   <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.item_kind      = r_kind;
    assign o_out.address_byte   = r_byte;
    assign o_out.address_target = r_target;
    assign o_out.command_code   = r_code;
    assign o_out.is_last        = r_last;

endmodule

/* design/smtp_command_address_extractor_unit.sv */
// top level of the smtp command address extractor: parser, bundle queue, output stage
// depends on sca_pkg, sca_in_if, sca_out_if, sca_front, sca_queue, sca_back
//
//   port       dir  handshake    payload
//   i_in_ch    in   valid/ready  data_byte[7:0], last_of_packet
//   o_out_ch   out  valid/ready  item_kind, address_byte[7:0], address_target,
//                                command_code[2:0], is_last
//
// the parser takes one byte per cycle while the 4-entry bundle queue has room
// a byte causes 0 to 3 result items; the output stage sends one item per cycle while o_out_ch.ready is high
// a result passes through the bundle queue and then the output register before it is valid
// reset is synchronous; no clearing pass
// output stalls back up into the queue and then hold i_in_ch.ready low
module smtp_command_address_extractor_unit #(
    parameter int unsigned ADDRESS_BYTES = 128,
    parameter int unsigned COMMAND_CHARS = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sca_in_if.sink     i_in_ch,
    sca_out_if.source  o_out_ch
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    sca_pkg::t_bundle  q_in;
    sca_pkg::t_bundle  q_head;

    // byte parser
    sca_front #(
        .ADDRESS_BYTES (ADDRESS_BYTES),
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_ch),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_bundle (q_in)
    );

    // bundle queue
    sca_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    // item output stage
    sca_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out_ch)
    );

endmodule

/* tb/smtp_command_address_extractor_unit_tb.sv */
`timescale 1ns / 100ps
// testbench for the smtp command address extractor: directed packets, then random smtp sessions, scoreboard check
// depends on sca_pkg, sca_in_if, sca_out_if and smtp_command_address_extractor_unit

package smtp_address_check_pkg;
    import sca_pkg::*;

    localparam int unsigned ADDR_BYTES = 128;
    localparam int unsigned CMD_CHARS  = 15;

    // characters the parser cares about
    localparam logic [7:0] ASC_SP    = 8'h20;
    localparam logic [7:0] ASC_TAB   = 8'h09;
    localparam logic [7:0] ASC_LF    = 8'h0a;
    localparam logic [7:0] ASC_VT    = 8'h0b;
    localparam logic [7:0] ASC_FF    = 8'h0c;
    localparam logic [7:0] ASC_CR    = 8'h0d;
    localparam logic [7:0] ASC_COLON = 8'h3a;
    localparam logic [7:0] ASC_LT    = 8'h3c;
    localparam logic [7:0] ASC_GT    = 8'h3e;
    localparam logic [7:0] ASC_DOT   = 8'h2e;
    localparam logic [7:0] ASC_LO_A  = 8'h61;
    localparam logic [7:0] ASC_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // command words, first letter in the top byte
    localparam logic [63:0] CMD_MAILFROM = "MAILFROM";
    localparam logic [63:0] CMD_RCPTTO   = {"RCPTTO", 16'h0000};
    localparam logic [63:0] CMD_DATA     = {"DATA", 32'h0000_0000};
    localparam logic [63:0] CMD_RSET     = {"RSET", 32'h0000_0000};
    localparam logic [63:0] CMD_MAIL     = {"MAIL", 32'h0000_0000};
    localparam logic [63:0] CMD_RCPT     = {"RCPT", 32'h0000_0000};

    typedef struct packed {
        t_kind      kind;
        logic [7:0] addr;
        logic       target;
        t_code      code;
        logic       last;
    } t_smtp_result;

    class address_scoreboard;
        // parser state mirrored from the block
        bit           in_data;
        t_phase       phase;
        logic [7:0]   letters [CMD_CHARS];
        int unsigned  nletters;
        int unsigned  naddr;
        logic [1:0]   blank_run;
        bit           blank_was_cr;
        t_dline       line_pos;

        t_smtp_result expected_results[$];
        int           failures;

        function new();
            in_data      = 1'b0;
            phase        = PH_LEAD;
            nletters     = 0;
            naddr        = 0;
            blank_run    = 2'd0;
            blank_was_cr = 1'b0;
            line_pos     = DL_START;
            failures     = 0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == ASC_SP || b == ASC_TAB || b == ASC_LF || b == ASC_VT ||
                   b == ASC_FF || b == ASC_CR;
        endfunction

        function bit word_equals(logic [63:0] w, int unsigned len);
            if (nletters != len) begin
                return 1'b0;
            end
            for (int i = 0; i < len; i++) begin
                if (letters[i] !== w[63-8*i -: 8]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function t_code command_of();
            if (word_equals(CMD_MAILFROM, 8)) return CODE_MAILFROM;
            if (word_equals(CMD_RCPTTO, 6)) return CODE_RCPTTO;
            if (word_equals(CMD_DATA, 4)) return CODE_DATA;
            if (word_equals(CMD_RSET, 4)) return CODE_RSET;
            return CODE_OTHER;
        endfunction

        function bit is_join();
            return word_equals(CMD_MAIL, 4) || word_equals(CMD_RCPT, 4);
        endfunction

        function void push_result(t_kind k, logic [7:0] ch, t_code c);
            t_smtp_result r;
            r.kind   = k;
            r.addr   = (k == KIND_ADDRESS) ? ch : 8'h00;
            r.target = (k == KIND_ADDRESS) && (c == CODE_RCPTTO);
            r.code   = c;
            r.last   = (k == KIND_SUMMARY);
            expected_results.push_back(r);
        endfunction

        // address output stops one short of the buffer size
        function void put_address_char(logic [7:0] ch);
            if (naddr >= ADDR_BYTES - 1) begin
                return;
            end
            naddr++;
            push_result(KIND_ADDRESS, ch, command_of());
        endfunction

        // a pending blank run becomes one space, a lone trailing cr may vanish
        function void flush_blank(bit strip_cr);
            if (blank_run != 2'd0 && !(strip_cr && blank_run == 2'd1 && blank_was_cr)) begin
                put_address_char(ASC_SP);
            end
            blank_run    = 2'd0;
            blank_was_cr = 1'b0;
        endfunction

        function void take_word_char(logic [7:0] b);
            if (b == ASC_COLON || is_blank(b)) begin
                phase = PH_SKIP;
                return;
            end
            if (nletters < CMD_CHARS) begin
                if (b >= ASC_LO_A && b <= ASC_LO_Z) begin
                    b = b - CASE_BIT;
                end
                letters[nletters] = b;
                nletters++;
            end
        endfunction

        function void take_param_char(logic [7:0] b);
            if (phase == PH_FIRST) begin
                phase = PH_COPY;
                if (b == ASC_LT) begin
                    return;
                end
            end
            if (b == ASC_LF) begin
                flush_blank(1'b1);
                phase = PH_IGNORE;
            end else if (b == ASC_GT) begin
                flush_blank(1'b0);
                phase = PH_IGNORE;
            end else if (is_blank(b)) begin
                if (blank_run < 2'd2) begin
                    blank_run++;
                end
                blank_was_cr = (b == ASC_CR);
            end else begin
                flush_blank(1'b0);
                put_address_char(b);
            end
        endfunction

        // data mode ends on a line holding only a dot, optionally followed by cr
        function void take_data_char(logic [7:0] b);
            bit done;
            done = 1'b0;
            case (line_pos)
                DL_START: begin
                    line_pos = (b == ASC_DOT) ? DL_DOT : (b == ASC_LF) ? DL_START : DL_MID;
                end
                DL_DOT: begin
                    if (b == ASC_LF) done = 1'b1;
                    else line_pos = (b == ASC_CR) ? DL_DOTCR : DL_MID;
                end
                DL_DOTCR: begin
                    if (b == ASC_LF) done = 1'b1;
                    else line_pos = DL_MID;
                end
                default: begin
                    line_pos = (b == ASC_LF) ? DL_START : DL_MID;
                end
            endcase
            if (done) begin
                in_data  = 1'b0;
                line_pos = DL_START;
                phase    = PH_ENDED;
            end
        endfunction

        // one accepted byte: advance the parser and queue what it produces
        function void note_byte(logic [7:0] b, logic last);
            t_code c;
            if (in_data) begin
                take_data_char(b);
            end else begin
                if (phase == PH_LEAD && !is_blank(b)) begin
                    phase = PH_WORD;
                end
                if (phase == PH_WORD) begin
                    take_word_char(b);
                end else if (phase == PH_SKIP) begin
                    if (!is_blank(b)) begin
                        if (is_join()) begin
                            phase = PH_WORD;
                            take_word_char(b);
                        end else begin
                            c = command_of();
                            phase = (c == CODE_MAILFROM || c == CODE_RCPTTO) ?
                                    PH_FIRST : PH_IGNORE;
                            if (phase == PH_FIRST) begin
                                take_param_char(b);
                            end
                        end
                    end
                end else if (phase == PH_FIRST || phase == PH_COPY) begin
                    take_param_char(b);
                end
            end

            // packet end: summary and parser restart
            if (last) begin
                if (phase == PH_COPY) begin
                    flush_blank(1'b1);
                end
                if (in_data) begin
                    c = CODE_DATA_LINE;
                end else if (phase == PH_ENDED) begin
                    c = CODE_DATA_END;
                end else if ((phase == PH_WORD || phase == PH_SKIP) && is_join()) begin
                    c = CODE_INCOMPLETE;
                end else begin
                    c = command_of();
                    if (c == CODE_DATA) begin
                        in_data  = 1'b1;
                        line_pos = DL_START;
                    end else if (c == CODE_RSET) begin
                        in_data = 1'b0;
                    end
                end
                push_result(KIND_SUMMARY, 8'h00, c);
                phase        = PH_LEAD;
                nletters     = 0;
                naddr        = 0;
                blank_run    = 2'd0;
                blank_was_cr = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_item(t_smtp_result got);
            t_smtp_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none, actual kind %0h byte %0h",
                         $time, got.kind, got.addr);
                $display("%0t:   target %0h code %0h last %0h",
                         $time, got.target, got.code, got.last);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("item_kind", 8'(want.kind), 8'(got.kind));
            compare_field("address_byte", want.addr, got.addr);
            compare_field("address_target", 8'(want.target), 8'(got.target));
            compare_field("command_code", 8'(want.code), 8'(got.code));
            compare_field("is_last", 8'(want.last), 8'(got.last));
        endfunction

        function void close();
            if (expected_results.size() != 0) begin
                $display("%0t: %0d more results expected, actual none",
                         $time, expected_results.size());
                failures++;
            end
        endfunction
    endclass
endpackage

module smtp_command_address_extractor_unit_tb;
    import sca_pkg::*;
    import smtp_address_check_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_WAIT     = 16;
    localparam int RANDOM_ITEMS = 350;
    localparam int TAIL_CYCLES  = 8;
    localparam int IDLE_LIMIT   = 256;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sca_in_if  in_ch ();
    sca_out_if out_ch ();

    smtp_command_address_extractor_unit #(
        .ADDRESS_BYTES(ADDR_BYTES),
        .COMMAND_CHARS(CMD_CHARS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch)
    );

    address_scoreboard sb = new();

    int         src_calm = 0;
    int         snk_calm = 0;
    int         long_left = 2;
    int         random_sent = 0;
    logic [7:0] pkt_bytes[$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // wait before the next transfer, with occasional stretches of none
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] pick_blank(bit allow_lf);
        case ($urandom_range(0, allow_lf ? 6 : 5))
            0, 1:    return ASC_SP;
            2:       return ASC_TAB;
            3:       return ASC_CR;
            4:       return ASC_VT;
            5:       return ASC_FF;
            default: return ASC_LF;
        endcase
    endfunction

    function automatic void add_blanks(int lo, int hi, bit allow_lf);
        repeat ($urandom_range(lo, hi)) pkt_bytes.push_back(pick_blank(allow_lf));
    endfunction

    function automatic void add_text(string s, bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && (c | CASE_BIT) >= ASC_LO_A && (c | CASE_BIT) <= ASC_LO_Z &&
                $urandom_range(0, 1) == 1) begin
                c = c ^ CASE_BIT;
            end
            pkt_bytes.push_back(c);
        end
    endfunction

    function automatic void add_crlf();
        pkt_bytes.push_back(ASC_CR);
        pkt_bytes.push_back(ASC_LF);
    endfunction

    function automatic logic [7:0] pick_addr_char();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0:       c = 8'($urandom_range(128, 255));
            1:       c = ASC_LT;
            default: begin
                c = 8'($urandom_range(33, 126));
                if (c == ASC_GT) c = ASC_DOT;
            end
        endcase
        return c;
    endfunction

    // sender or recipient command with a random address and ending
    function automatic void add_address_command(bit rcpt, bit long_addr);
        int n;
        add_blanks(0, 2, 1'b1);
        if (rcpt) add_text("rcpt", 1'b1);
        else add_text("mail", 1'b1);
        case ($urandom_range(0, 2))
            0:       pkt_bytes.push_back(ASC_SP);
            1:       pkt_bytes.push_back(ASC_COLON);
            default: add_blanks(1, 3, 1'b1);
        endcase
        if (rcpt) add_text("to", 1'b1);
        else add_text("from", 1'b1);
        pkt_bytes.push_back(($urandom_range(0, 6) != 0) ? ASC_COLON : ASC_SP);
        add_blanks(0, 2, 1'b1);
        if ($urandom_range(0, 4) != 0) pkt_bytes.push_back(ASC_LT);
        n = long_addr ? $urandom_range(130, 150) : $urandom_range(0, 12);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) add_blanks(1, 3, 1'b0);
            else pkt_bytes.push_back(pick_addr_char());
        end
        case ($urandom_range(0, 9))
            0, 1, 2: pkt_bytes.push_back(ASC_GT);
            3: begin
                pkt_bytes.push_back(ASC_GT);
                add_text(" SIZE=1", 1'b0);
                add_crlf();
            end
            4, 5: add_crlf();
            6: begin
                // bytes after the line feed are ignored
                add_crlf();
                add_text("x y", 1'b0);
            end
            7: ;
            default: add_blanks(1, 2, 1'b0);
        endcase
    endfunction

    // unknown word, sometimes longer than the command buffer
    function automatic void add_other_word();
        int n;
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) begin
            add_text("MAILFROM", 1'b1);
            n = $urandom_range(8, 12);
        end else begin
            n = $urandom_range(1, 12);
        end
        repeat (n) begin
            c = 8'($urandom_range(65, 90));
            if ($urandom_range(0, 1) == 1) c = c | CASE_BIT;
            pkt_bytes.push_back(c);
        end
        if ($urandom_range(0, 1) == 1) begin
            add_text(" arg", 1'b0);
            add_crlf();
        end
    endfunction

    // message body fragments, end-of-data lines among them
    function automatic void add_data_piece();
        case ($urandom_range(0, 7))
            0, 1: begin
                repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 1) == 1) add_crlf();
                else pkt_bytes.push_back(ASC_LF);
            end
            2: begin
                pkt_bytes.push_back(ASC_DOT);
                add_crlf();
            end
            3: begin
                pkt_bytes.push_back(ASC_DOT);
                pkt_bytes.push_back(ASC_LF);
            end
            4: begin
                pkt_bytes.push_back(ASC_DOT);
                pkt_bytes.push_back(ASC_DOT);
                add_crlf();
            end
            5: pkt_bytes.push_back(ASC_DOT);
            6: pkt_bytes.push_back(ASC_LF);
            default: repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void build_packet();
        int r;
        if (sb.in_data) begin
            repeat ($urandom_range(1, 3)) add_data_piece();
        end else if (long_left > 0 && $urandom_range(0, 5) == 0) begin
            add_address_command(1'($urandom_range(0, 1)), 1'b1);
            long_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                add_address_command(1'b0, 1'b0);
            end else if (r < 55) begin
                add_address_command(1'b1, 1'b0);
            end else if (r < 65) begin
                add_blanks(0, 1, 1'b1);
                add_text("data", 1'b1);
                if (r < 62) add_crlf();
                else add_text(" now", 1'b0);
            end else if (r < 72) begin
                add_text("rset", 1'b1);
                add_crlf();
            end else if (r < 78) begin
                // join word with at most a colon and blanks after it
                if (r < 75) add_text("mail", 1'b1);
                else add_text("rcpt", 1'b1);
                if ($urandom_range(0, 1) == 1) pkt_bytes.push_back(ASC_COLON);
                add_blanks(0, 2, 1'b1);
            end else if (r < 84) begin
                add_other_word();
            end else if (r < 90) begin
                add_blanks(1, 3, 1'b1);
            end else begin
                repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // one input transfer, noted in the scoreboard once accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int w;
        w = pick_wait(src_calm);
        if (w > 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.last_of_packet <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b, last);
    endtask

    task automatic send_packet();
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(pkt_bytes[i], i == n - 1);
        end
        pkt_bytes.delete();
    endtask

    // result side: random stalls, check every transfer
    initial begin : result_sink
        int w;
        t_smtp_result got;
        out_ch.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            w = pick_wait(snk_calm);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            got.kind   = t_kind'(out_ch.item_kind);
            got.addr   = out_ch.address_byte;
            got.target = out_ch.address_target;
            got.code   = t_code'(out_ch.command_code);
            got.last   = out_ch.is_last;
            sb.check_item(got);
        end
    end

    // no transfer on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
            else idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.last_of_packet <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lowest and highest byte as one-byte commands
        pkt_bytes.push_back(8'h00);
        send_packet();
        pkt_bytes.push_back(8'hff);
        send_packet();
        // blank packet
        pkt_bytes.push_back(ASC_SP);
        pkt_bytes.push_back(ASC_CR);
        pkt_bytes.push_back(ASC_LF);
        send_packet();
        // join word alone
        add_text("mail", 1'b0);
        send_packet();
        // recipient with bracketed address
        add_text("rcpt to:<x>", 1'b0);
        send_packet();
        // into data mode and straight out again
        add_text("DATA", 1'b0);
        send_packet();
        pkt_bytes.push_back(ASC_DOT);
        pkt_bytes.push_back(ASC_LF);
        send_packet();

        // random session traffic
        while (random_sent < RANDOM_ITEMS) begin
            build_packet();
            random_sent += pkt_bytes.size();
            send_packet();
        end
        in_ch.valid <= 1'b0;

        // drain and settle
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.close();
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
